// ----- sv/afol_pkg.sv -----
// Shared types and constants of the adaptive first-order low-pass filter.
package afol_pkg;

    // Gain format: Q0.16, unity is 2^16, one extra bit holds unity itself
    localparam int GAIN_FRAC   = 16;
    localparam int GAIN_W      = GAIN_FRAC + 1;
    localparam int TICK_W      = 32;
    localparam int TC_W        = 20;
    localparam int DIVISOR_W   = TICK_W + 1;
    localparam int DIV_CNT_W   = $clog2(GAIN_FRAC);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [GAIN_W-1:0] GAIN_ONE       = GAIN_W'(1) << GAIN_FRAC;
    localparam logic [GAIN_W-1:0] FIXED_GAIN_RST = GAIN_ONE;
    localparam logic [TICK_W-1:0] GAP_LIMIT_RST  = TICK_W'(300);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_MODE = 2'd0,
        REG_FIXED_GAIN  = 2'd1,
        REG_TIME_CONST  = 2'd2,
        REG_GAP_LIMIT   = 2'd3
    } t_cfg_reg;

    // Filter modes
    localparam logic MODE_FIXED = 1'b0;
    localparam logic MODE_TIMED = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_UPD,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic prep;      // form difference, pick gain, track tick
        logic restart;   // jump value to the sample
        logic div_init;  // start gain division
        logic div_step;  // one quotient bit
        logic mul_lo;    // low partial product
        logic mul_hi;    // high partial product
        logic acc;       // combine partial products
        logic upd;       // add scaled step, saturate
        logic out_load;  // move result into output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic timed;
        logic gap_over;
        logic tc_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/afol_div.sv -----
// Restoring divider: gain = dt * 2^16 / (time_constant + dt), one bit per cycle.
module afol_div
    import afol_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_init,
    input  logic                  i_step,
    input  logic [TICK_W-1:0]     i_dt,
    input  logic [TC_W-1:0]       i_tc,
    output logic [GAIN_FRAC-1:0]  o_quotient,
    output logic                  o_last
);

    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [GAIN_FRAC-1:0] r_quot;
    logic [DIV_CNT_W-1:0] r_count;

    logic [DIVISOR_W:0]   w_shift;
    logic [DIVISOR_W:0]   w_sub;
    logic                 w_ge;

    // Trial subtract of the doubled remainder
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_ge    = w_shift >= {1'b0, r_divisor};
        w_sub   = w_shift - {1'b0, r_divisor};
    end

    // Load operands or advance one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem     <= {1'b0, i_dt};
            r_divisor <= {1'b0, i_dt} + DIVISOR_W'(i_tc);
            r_quot    <= '0;
            r_count   <= '0;
        end else if (i_step) begin
            r_rem     <= w_ge ? w_sub[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quot    <= {r_quot[GAIN_FRAC-2:0], w_ge};
            r_count   <= r_count + DIV_CNT_W'(1);
        end
    end

    assign o_quotient = r_quot;
    assign o_last     = (r_count == DIV_CNT_W'(GAIN_FRAC - 1));

endmodule

// ----- sv/afol_dp.sv -----
// Datapath: configuration registers, filter state, gain, multiply and output register.
module afol_dp
    import afol_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic                          i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [TICK_W-1:0]             i_tick,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_restarted
);

    localparam int VB   = SAMPLE_BITS + FRACTION_BITS;  // state width
    localparam int DW   = VB + 1;                        // difference width
    localparam int LW   = (DW + 1) / 2;                  // low split of difference
    localparam int HW   = DW - LW;                       // high split of difference
    localparam int MW   = LW + 1;                        // multiplier operand
    localparam int PMW  = MW + GAIN_W + 1;               // multiplier product
    localparam int SUMW = DW + GAIN_W + 1;               // full product
    localparam int DLW  = SUMW - GAIN_FRAC;              // scaled step
    localparam int NW   = DW + 3;                        // update sum

    localparam logic signed [NW-1:0] VALUE_MAX = NW'((64'd1 << (VB - 1)) - 64'd1);
    localparam logic signed [NW-1:0] VALUE_MIN = -VALUE_MAX - NW'(1);

    // Configuration
    logic                  r_filter_mode;
    logic [GAIN_W-1:0]     r_fixed_gain;
    logic [TC_W-1:0]       r_time_const;
    logic [TICK_W-1:0]     r_gap_limit;

    // Filter state
    logic signed [VB-1:0]  r_value;
    logic [TICK_W-1:0]     r_prev_tick;

    // Item in flight
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [TICK_W-1:0]     r_tick;
    logic [TICK_W-1:0]     r_dt;
    logic signed [DW-1:0]  r_diff;
    logic [GAIN_W-1:0]     r_gain;
    logic                  r_use_div;
    logic                  r_restarted;
    logic signed [PMW-1:0] r_prod_lo;
    logic signed [PMW-1:0] r_prod_hi;
    logic signed [SUMW-1:0] r_prod;

    // Output register
    logic                  r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_filtered;
    logic                  r_out_restarted;

    logic [GAIN_FRAC-1:0]  w_quotient;
    logic                  w_div_last;
    logic signed [VB-1:0]  w_target;
    logic signed [DW-1:0]  n_diff;
    logic [GAIN_W-1:0]     w_gain;
    logic signed [MW-1:0]  w_mul_a;
    logic signed [GAIN_W:0] w_mul_b;
    logic signed [PMW-1:0] w_mul_p;
    logic signed [SUMW-1:0] n_prod;
    logic signed [DLW-1:0] w_delta;
    logic signed [NW-1:0]  w_sum;
    logic signed [VB-1:0]  n_value;

    afol_div u_div (
        .i_clk      (i_clk),
        .i_init     (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_dt       (r_dt),
        .i_tc       (r_time_const),
        .o_quotient (w_quotient),
        .o_last     (w_div_last)
    );

    // Target and difference in state format
    always_comb begin
        w_target = {r_sample, {FRACTION_BITS{1'b0}}};
        n_diff   = DW'(w_target) - DW'(r_value);
        if (VB + 1 == DW) begin
            n_diff = {w_target[VB-1], w_target} - {r_value[VB-1], r_value};
        end
    end

    // Shared multiplier: unsigned low part, then signed high part of the difference
    always_comb begin
        w_gain  = r_use_div ? {1'b0, w_quotient} : r_gain;
        w_mul_b = {1'b0, w_gain};
        if (i_cmd.mul_hi) begin
            w_mul_a = {{(MW-HW){r_diff[DW-1]}}, r_diff[DW-1:LW]};
        end else begin
            w_mul_a = {1'b0, r_diff[LW-1:0]};
        end
        w_mul_p = w_mul_a * w_mul_b;
    end

    // Combine partial products, then floor-shift and saturate
    always_comb begin
        n_prod  = SUMW'({{(SUMW-PMW){r_prod_hi[PMW-1]}}, r_prod_hi} <<< LW)
                + {{(SUMW-PMW){r_prod_lo[PMW-1]}}, r_prod_lo};
        w_delta = r_prod[SUMW-1:GAIN_FRAC];
        w_sum   = {{(NW-VB){r_value[VB-1]}}, r_value}
                + {{(NW-DLW){w_delta[DLW-1]}}, w_delta};
        if (w_sum > VALUE_MAX) begin
            n_value = VALUE_MAX[VB-1:0];
        end else if (w_sum < VALUE_MIN) begin
            n_value = VALUE_MIN[VB-1:0];
        end else begin
            n_value = w_sum[VB-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= MODE_FIXED;
            r_fixed_gain  <= FIXED_GAIN_RST;
            r_time_const  <= '0;
            r_gap_limit   <= GAP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FILTER_MODE: r_filter_mode <= i_cfg_data[0];
                REG_FIXED_GAIN:  r_fixed_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_TIME_CONST:  r_time_const  <= i_cfg_data[TC_W-1:0];
                REG_GAP_LIMIT:   r_gap_limit   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Filter state: restart jump, update, tick tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value     <= '0;
            r_prev_tick <= '0;
        end else begin
            if (i_cmd.prep && r_filter_mode == MODE_TIMED) begin
                r_prev_tick <= r_tick;
            end
            if (i_cmd.restart) begin
                r_value <= w_target;
            end else if (i_cmd.upd) begin
                r_value <= n_value;
            end
        end
    end

    // Item in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_tick   <= i_tick;
            r_dt     <= i_tick - r_prev_tick;
        end
        if (i_cmd.prep) begin
            r_diff      <= n_diff;
            r_restarted <= i_cmd.restart;
            r_use_div   <= i_cmd.div_init;
            r_gain      <= (r_filter_mode == MODE_TIMED) ? GAIN_ONE : r_fixed_gain;
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= w_mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= w_mul_p;
        end
        if (i_cmd.acc) begin
            r_prod <= n_prod;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_filtered  <= r_value[VB-1:FRACTION_BITS];
            r_out_restarted <= r_restarted;
        end
    end

    always_comb begin
        o_status.timed    = (r_filter_mode == MODE_TIMED);
        o_status.gap_over = (r_dt > r_gap_limit);
        o_status.tc_zero  = (r_time_const == '0);
        o_status.div_last = w_div_last;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out_filtered;
    assign o_restarted = r_out_restarted;

endmodule

// ----- sv/afol_ctrl.sv -----
// Controller: sequences one item through prepare, divide, multiply and update.
module afol_ctrl
    import afol_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (i_status.timed && i_status.gap_over) begin
                    n_state = S_DONE;
                end else if (i_status.timed && !i_status.tc_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_ACC;
            S_ACC:    n_state = S_UPD;
            S_UPD:    n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PREP: begin
                o_cmd.prep     = 1'b1;
                o_cmd.restart  = i_status.timed && i_status.gap_over;
                o_cmd.div_init = i_status.timed && !i_status.gap_over && !i_status.tc_zero;
            end
            S_DIV:    o_cmd.div_step = 1'b1;
            S_MUL_LO: o_cmd.mul_lo   = 1'b1;
            S_MUL_HI: o_cmd.mul_hi   = 1'b1;
            S_ACC:    o_cmd.acc      = 1'b1;
            S_UPD:    o_cmd.upd      = 1'b1;
            S_DONE:   o_cmd.out_load = i_status.out_free;
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/adaptive_first_order_lowpass.sv -----
// Top level: first-order low-pass filter with fixed or tick-timed gain.
// Sequence: after the input transaction the item passes S_PREP, then goes to S_DONE
// on a gap restart; in fixed mode or with a zero time constant it passes S_MUL_LO,
// S_MUL_HI, S_ACC and S_UPD, and in timed mode the gain divider (S_DIV) comes first.
// S_DONE loads the output register once it is free. Input is taken only in S_IDLE;
// the next item is taken while a finished result still waits in the output register.
// Reset (i_rst_n low, synchronous): configuration registers to their defaults, value and last tick to 0.
module adaptive_first_order_lowpass
    import afol_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // sample, current_tick
    input  logic [((SAMPLE_BITS+TICK_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // filtered
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // restarted
    output logic                        o_m_axis_tuser
);

    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic signed [SAMPLE_BITS-1:0] w_filtered;

    afol_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    afol_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_tick      (i_s_axis_tdata[SAMPLE_BITS+TICK_W-1:SAMPLE_BITS]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_filtered  (w_filtered),
        .o_restarted (o_m_axis_tuser)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_TDATA_W'($unsigned(w_filtered));

    // A new transaction is always followed by the prepare step
    a_load_then_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> w_cmd.prep)
        else $error("prepare step did not follow an input transaction");

    // A result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register loaded while still full");

    // No result appears the cycle after an input transaction unless one was pending
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("result appeared before the item was processed");

    // Load, divide-step, multiply, combine, update and output-load commands are mutually exclusive
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.div_step, w_cmd.mul_lo, w_cmd.mul_hi,
                  w_cmd.acc, w_cmd.upd, w_cmd.out_load}))
        else $error("more than one datapath step commanded");

endmodule
